### src/rdt_pkg.sv
// shared types and constants for the reload down timer
package rdt_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  localparam logic       WORD_CTRL  = 1'b0;
  localparam logic       WORD_COUNT = 1'b1;

  localparam int unsigned CtlBits   = 3;
  localparam logic [2:0] CTL_MASK   = 3'h7;
  localparam logic [2:0] CTL_RUN    = 3'h1;
  localparam logic [2:0] CTL_PRESET = 3'h2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        word_select;
    logic [15:0] write_data;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        underflow_irq;
  } result_t;

endpackage

### src/rdt_core.sv
// timer state registers and the per-word update and read logic
module rdt_core
  import rdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  item_t       item_i,
  input  logic [15:0] prescale_i,
  output result_t     result_o
);

  logic [CtlBits-1:0] ctl_q, ctl_d;
  logic [7:0]         reload_q, reload_d;
  logic [7:0]         count_q, count_d;
  logic [15:0]        left_q, left_d;
  cmd_e               cmd;

  assign cmd = cmd_e'(item_i.cmd);

  always_comb begin
    ctl_d    = ctl_q;
    reload_d = reload_q;
    count_d  = count_q;
    left_d   = left_q;
    result_o = '0;
    case (cmd)
      CMD_READ: begin
        if (item_i.word_select == WORD_CTRL) begin
          result_o.read_data = {reload_q, 5'd0, ctl_q};
        end else begin
          result_o.read_data = {8'd0, count_q};
        end
      end
      CMD_WRITE: begin
        if (item_i.word_select == WORD_CTRL) begin
          ctl_d = item_i.write_data[CtlBits-1:0] & CTL_MASK;
          // preset takes the reload value from before this write
          if ((ctl_d & CTL_PRESET) != '0) begin
            count_d = reload_q;
          end
          reload_d = item_i.write_data[15:8];
        end
      end
      CMD_TICK: begin
        if ((ctl_q & CTL_RUN) != '0 && prescale_i != 16'd0) begin
          if (left_q == 16'd0) begin
            left_d = prescale_i - 16'd1;
            if (count_q == 8'd0) begin
              count_d                = reload_q;
              result_o.underflow_irq = 1'b1;
            end else begin
              count_d = count_q - 8'd1;
            end
          end else begin
            left_d = left_q - 16'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q    <= '0;
      reload_q <= '0;
      count_q  <= '0;
      left_q   <= '0;
    end else if (take_i) begin
      ctl_q    <= ctl_d;
      reload_q <= reload_d;
      count_q  <= count_d;
      left_q   <= left_d;
    end
  end

endmodule

### src/reload_down_timer_8bit.sv
// a result word appears in the cycle after its input word is accepted
// throughput: one word per cycle unless a held result waits on ready_i, set by the single output register stage
// ready_o stays high while the output register is empty or being drained
// reset: async active low; control, reload, counter, prescaler and the
// prescale register clear to zero, output register empties
module reload_down_timer_8bit
  import rdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // prescale register write
  input  logic        prescale_we_i,
  input  logic [15:0] prescale_cycles_i,
  // input word channel
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  cmd_i,
  input  logic        word_select_i,
  input  logic [15:0] write_data_i,
  // result word channel
  output logic        valid_o,
  input  logic        ready_i,
  output logic [15:0] read_data_o,
  output logic        underflow_irq_o
);

  logic [15:0] prescale_q;
  logic        out_valid_q, out_valid_d;
  result_t     out_q;
  result_t     result;
  item_t       item;
  logic        take;

  // accept whenever the output slot is free or is emptied this cycle
  assign ready_o = !out_valid_q || ready_i;
  assign take    = valid_i && ready_o;

  assign item.cmd         = cmd_i;
  assign item.word_select = word_select_i;
  assign item.write_data  = write_data_i;

  // the user must change prescale only while idle; the block does not enforce this, it is a plain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= '0;
    end else if (prescale_we_i) begin
      prescale_q <= prescale_cycles_i;
    end
  end

  rdt_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .item_i     (item),
    .prescale_i (prescale_q),
    .result_o   (result)
  );

  // output register: filled on accept, cleared when drained with nothing new
  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= result;
    end
  end

  assign valid_o         = out_valid_q;
  assign read_data_o     = out_q.read_data;
  assign underflow_irq_o = out_q.underflow_irq;

endmodule

### src/rdt_checker.sv
// port-level checks for the reload down timer
module rdt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_o,
  input logic        valid_o,
  input logic        ready_i,
  input logic [15:0] read_data_o,
  input logic        underflow_irq_o
);

  // every accepted word yields a result the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> valid_o)
    else $error("accepted word produced no result");

  // an empty output slot never blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> ready_o)
    else $error("input stalled with empty output");

  // an underflow comes from a tick, which reads nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && underflow_irq_o |-> read_data_o == 16'd0)
    else $error("underflow with nonzero read data");

  // a pending result is not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(read_data_o))
    else $error("stalled result lost or changed");

endmodule

bind reload_down_timer_8bit rdt_checker u_rdt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .valid_i         (valid_i),
  .ready_o         (ready_o),
  .valid_o         (valid_o),
  .ready_i         (ready_i),
  .read_data_o     (read_data_o),
  .underflow_irq_o (underflow_irq_o)
);
